FILE: sv/cspt_pkg.sv
package cspt_pkg;

    // Fixed field widths
    localparam int POS_W = 12;
    localparam int FULL_POS = 4095;

    // Item opcodes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_CMD     = 2'd1;
    localparam logic [1:0] OP_RESTORE = 2'd2;

    // Motion codes
    localparam logic [1:0] MOT_IDLE = 2'd0;
    localparam logic [1:0] MOT_UP   = 2'd1;
    localparam logic [1:0] MOT_DOWN = 2'd2;

    // Drive direction codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_CW   = 2'd1;
    localparam logic [1:0] DIR_CCW  = 2'd2;

    // Config register indexes
    localparam logic [1:0] CFG_ENABLED    = 2'd0;
    localparam logic [1:0] CFG_CALIB_MODE = 2'd1;
    localparam logic [1:0] CFG_MOUNT_LEFT = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [1:0]       new_state;
        logic [POS_W-1:0] restore_position;
        logic [POS_W-1:0] restore_max;
    } item_t;

    typedef struct packed {
        logic             step_issue;
        logic [1:0]       direction;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] max_position;
        logic [1:0]       motion_state;
        logic             save_request;
    } res_t;

    typedef struct packed {
        logic enabled;
        logic calib_mode;
        logic mount_left;
    } cfg_t;

endpackage

FILE: sv/cspt_core.sv
module cspt_core import cspt_pkg::*; #(
    parameter int MAX_STEPS      = 4095,
    parameter int STEPS_PER_TURN = 20
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  fire,
    input  item_t item,
    output res_t  res
);

    localparam int POS_CAP_I = (MAX_STEPS > FULL_POS) ? FULL_POS : MAX_STEPS;
    localparam int MIN_POS_I = (STEPS_PER_TURN > POS_CAP_I) ? POS_CAP_I : STEPS_PER_TURN;
    localparam int LIM_RST_I = (2 * STEPS_PER_TURN > POS_CAP_I) ? POS_CAP_I
                                                                : 2 * STEPS_PER_TURN;
    localparam logic [POS_W-1:0] POS_CAP = POS_CAP_I[POS_W-1:0];
    localparam logic [POS_W-1:0] MIN_POS = MIN_POS_I[POS_W-1:0];
    localparam logic [POS_W-1:0] LIM_RST = LIM_RST_I[POS_W-1:0];

    logic [1:0]       cur_reg,  cur_next;
    logic [1:0]       prev_reg, prev_next;
    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [POS_W-1:0] lim_reg,  lim_next;
    logic [1:0]       dir_reg,  dir_next;
    logic             step;
    logic             save;

    always_comb begin
        cur_next  = cur_reg;
        prev_next = prev_reg;
        pos_next  = pos_reg;
        lim_next  = lim_reg;
        dir_next  = dir_reg;
        step      = 1'b0;
        save      = 1'b0;
        case (item.op)
            OP_TICK: begin
                if (cfg.enabled && !(cur_reg == MOT_IDLE && prev_reg == MOT_IDLE)) begin
                    // apply pending motion change
                    if (prev_reg != cur_reg) begin
                        if (cur_reg == MOT_UP) begin
                            dir_next = cfg.mount_left ? DIR_CCW : DIR_CW;
                        end else if (cur_reg == MOT_DOWN) begin
                            dir_next = cfg.mount_left ? DIR_CW : DIR_CCW;
                            if (cfg.calib_mode) begin
                                pos_next = MIN_POS;
                            end
                        end else begin
                            save     = 1'b1;
                            dir_next = DIR_STOP;
                            if (cfg.calib_mode && prev_reg == MOT_DOWN) begin
                                lim_next = pos_reg;
                            end
                        end
                        prev_next = cur_reg;
                    end
                    // end stops in work mode
                    if (!cfg.calib_mode) begin
                        if ((cur_next == MOT_UP && pos_next == MIN_POS) ||
                            (cur_next == MOT_DOWN && pos_next == lim_next)) begin
                            prev_next = cur_next;
                            cur_next  = MOT_IDLE;
                        end
                    end
                    if (cur_next == MOT_UP) begin
                        step = 1'b1;
                        if (pos_next != '0) begin
                            pos_next = pos_next - 1'b1;
                        end
                    end else if (cur_next == MOT_DOWN) begin
                        step = 1'b1;
                        if (pos_next < POS_CAP) begin
                            pos_next = pos_next + 1'b1;
                        end
                    end
                end
            end
            OP_CMD: begin
                prev_next = cur_reg;
                cur_next  = (item.new_state == MOT_UP || item.new_state == MOT_DOWN)
                            ? item.new_state : MOT_IDLE;
            end
            OP_RESTORE: begin
                pos_next = (item.restore_position > POS_CAP) ? POS_CAP : item.restore_position;
                lim_next = (item.restore_max > POS_CAP) ? POS_CAP : item.restore_max;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg  <= MOT_IDLE;
            prev_reg <= MOT_IDLE;
            pos_reg  <= MIN_POS;
            lim_reg  <= LIM_RST;
            dir_reg  <= DIR_STOP;
        end else if (fire) begin
            cur_reg  <= cur_next;
            prev_reg <= prev_next;
            pos_reg  <= pos_next;
            lim_reg  <= lim_next;
            dir_reg  <= dir_next;
        end
    end

    assign res.step_issue   = step;
    assign res.direction    = dir_next;
    assign res.position     = pos_next;
    assign res.max_position = lim_next;
    assign res.motion_state = cur_next;
    assign res.save_request = save;

endmodule

FILE: sv/curtain_stepper_position_tracker.sv
// Pipeline: each word passes through the input reg and then the result reg, and is
//   offered on m_valid from the result reg.
// Throughput: 1 word per cycle while m_ready keeps the result reg draining; the tracker
//   state updates in the same cycle the word moves from the input reg into the result reg.
// Reset: aresetn sync active low; both stages empty, motion idle, direction stop,
//   position = one turn, limit = two turns, enabled = 1, calib = 0, mount_left = 1.
module curtain_stepper_position_tracker import cspt_pkg::*; #(
    parameter int MAX_STEPS      = 4095,
    parameter int STEPS_PER_TURN = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  item_t       s_data,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output res_t        m_data,
    // config writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data
);

    logic  in_valid_reg, in_valid_next;
    item_t in_item_reg;
    logic  out_valid_reg, out_valid_next;
    res_t  out_res_reg;
    cfg_t  cfg_reg, cfg_next;
    res_t  core_res;
    logic  adv;

    // Word moves from input reg to result reg when result reg is free or draining.
    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (adv) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (adv) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Config registers; writes always taken. Index three is ignored.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_ENABLED:    cfg_next.enabled    = cfg_data;
                CFG_CALIB_MODE: cfg_next.calib_mode = cfg_data;
                CFG_MOUNT_LEFT: cfg_next.mount_left = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            cfg_reg.enabled     <= 1'b1;
            cfg_reg.calib_mode  <= 1'b0;
            cfg_reg.mount_left  <= 1'b1;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    // Payload regs, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (adv) begin
            out_res_reg <= core_res;
        end
    end

    // Tracker state and per-word update logic
    cspt_core #(
        .MAX_STEPS      (MAX_STEPS),
        .STEPS_PER_TURN (STEPS_PER_TURN)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .fire    (adv),
        .item    (in_item_reg),
        .res     (core_res)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_res_reg;

endmodule

FILE: sv/cspt_checker.sv
module cspt_checker import cspt_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input res_t m_data
);

    // No result straight out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // A step only happens while moving
    a_step_moving: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.step_issue |-> m_data.motion_state != MOT_IDLE)
        else $error("step issued while idle");

    // A save pulse comes with a stop
    a_save_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.save_request |->
            m_data.direction == DIR_STOP && !m_data.step_issue &&
            m_data.motion_state == MOT_IDLE)
        else $error("save request without stop");

endmodule

bind curtain_stepper_position_tracker cspt_checker u_cspt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
